/* rtl/lfle_pkg.sv */
// Shared types, constants and register codes for the login failure lockout engine.
`default_nettype none
package lfle_pkg;

   localparam int SLOT_COUNT_DEF = 8;

   localparam logic [7:0]  IP_FAIL_LIMIT_RST   = 8'd3;
   localparam logic [26:0] IP_LOCK_BASE_RST    = 27'd30000;
   localparam logic [26:0] IP_LOCK_CAP_RST     = 27'd900000;
   localparam logic [7:0]  GLB_FAIL_LIMIT_RST  = 8'd10;
   localparam logic [26:0] GLB_LOCK_BASE_RST   = 27'd120000;
   localparam logic [26:0] GLB_LOCK_CAP_RST    = 27'd3600000;
   localparam logic [26:0] IDLE_FORGET_RST     = 27'd3600000;
   localparam logic [26:0] ESC_FORGET_RST      = 27'd21600000;

   localparam logic [7:0]  LEVEL_MAX = 8'd255;

   typedef enum logic [1:0] {
      OP_QUERY   = 2'd0,
      OP_FAILURE = 2'd1,
      OP_SUCCESS = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_IP_FAIL_LIMIT  = 3'd0,
      REG_IP_LOCK_BASE   = 3'd1,
      REG_IP_LOCK_CAP    = 3'd2,
      REG_GLB_FAIL_LIMIT = 3'd3,
      REG_GLB_LOCK_BASE  = 3'd4,
      REG_GLB_LOCK_CAP   = 3'd5,
      REG_IDLE_FORGET    = 3'd6,
      REG_ESC_FORGET     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] source_addr;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        is_locked;
      logic [26:0] remain_ms;
      logic        lock_started;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  ip_fail_limit;
      logic [26:0] ip_lock_base;
      logic [26:0] ip_lock_cap;
      logic [7:0]  global_fail_limit;
      logic [26:0] global_lock_base;
      logic [26:0] global_lock_cap;
      logic [26:0] idle_forget_time;
      logic [26:0] escalation_forget_time;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_start; // reset scan pointer and search results
      logic scan_step;  // examine one slot
      logic bo_start;   // load backoff units
      logic bo_step;    // one doubling step
      logic commit;     // write back slot / global record, form result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic bo_done;
   } dp_sts_type;

endpackage
`default_nettype wire

/* rtl/login_failure_lockout_engine.sv */
// Top level of the login failure lockout engine.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    req_data  (op, source_addr, now_ms)
//   rsp_     out  rsp_valid/rsp_ready    rsp_data  (is_locked, remain_ms, lock_started)
//   csr_     in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One beat at a time. After the accepting edge the sequencer steps through the
// slot scan, the backoff load, the backoff doubling (n doubling steps, 0..27,
// the larger of the address and global level, stopping at the cap) and the
// commit, which registers the result. The request side stays not ready while
// a result is held.
// Synchronous reset clears all table and global state and loads register
// defaults; no clearing pass is needed.
`default_nettype none
module login_failure_lockout_engine
   import lfle_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [26:0] csr_data
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   lfle_regs u_regs (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg
   );

   lfle_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .sts
   );

   lfle_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
      .clock, .reset, .req_data, .cfg, .cmd, .sts, .rsp_data
   );

endmodule
`default_nettype wire

/* rtl/lfle_ctrl.sv */
// Sequencer for the lockout engine: handshakes and command timing.
`default_nettype none
module lfle_ctrl
   import lfle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_BOLOAD, ST_BACKOFF, ST_COMMIT, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_BOLOAD;
            end
         end
         ST_BOLOAD: begin
            // scan results are settled here
            cmd.bo_start = 1'b1;
            state_in     = ST_BACKOFF;
         end
         ST_BACKOFF: begin
            cmd.bo_step = 1'b1;
            if (sts.bo_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_RESP)
      else $error("response valid outside response state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_SCAN)
      else $error("accepted beat did not start scan");

endmodule
`default_nettype wire

/* rtl/lfle_dp.sv */
// Datapath: slot table, global record, serial scan and backoff doubling.
`default_nettype none
module lfle_dp
   import lfle_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire cfg_type    cfg,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts,
   output rsp_type         rsp_data
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   // slot table
   logic        valid_ff     [SLOT_COUNT];
   logic [31:0] addr_ff      [SLOT_COUNT];
   logic [7:0]  fcnt_ff      [SLOT_COUNT];
   logic [7:0]  lvl_ff       [SLOT_COUNT];
   logic        lck_ff       [SLOT_COUNT];
   logic [31:0] lstart_ff    [SLOT_COUNT];
   logic [26:0] llen_ff      [SLOT_COUNT];
   logic [31:0] lfail_ff     [SLOT_COUNT];

   // global record
   logic [7:0]  gcnt_ff, glvl_ff;
   logic        glck_ff, gever_ff;
   logic [31:0] gstart_ff, glast_ff;
   logic [26:0] glen_ff;

   req_type     req_ff;
   rsp_type     rsp_ff;

   // scan results
   logic [CW-1:0] ptr_ff;
   logic          hit_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, old_idx_ff;
   logic [31:0]   old_age_ff;

   // backoff units; one spare bit so a doubling past 27 bits still beats the cap
   logic [27:0] sbo_ff, gbo_ff;
   logic [7:0]  sk_ff, gk_ff;

   logic [IW-1:0] pidx;
   logic [31:0]   page;
   assign pidx = ptr_ff[IW-1:0];
   assign page = req_ff.now_ms - lfail_ff[pidx];

   assign sts.scan_done = (ptr_ff == CW'(SLOT_COUNT - 1));

   // selected slot for this beat
   logic [IW-1:0] sel;
   logic          sel_new;
   always_comb begin
      if (hit_ff) begin
         sel = hit_idx_ff; sel_new = 1'b0;
      end else if (free_ff) begin
         sel = free_idx_ff; sel_new = 1'b1;
      end else begin
         sel = old_idx_ff; sel_new = 1'b1;
      end
   end

   // aged view of the selected slot
   logic        a_valid, a_lck;
   logic [7:0]  a_fcnt, a_lvl;
   always_comb begin
      a_valid = valid_ff[sel] && !sel_new;
      a_lck   = lck_ff[sel] && a_valid;
      a_fcnt  = a_valid ? fcnt_ff[sel] : 8'd0;
      a_lvl   = a_valid ? lvl_ff[sel] : 8'd0;
      if (a_valid && (req_ff.now_ms - lfail_ff[sel]) >= 32'(cfg.idle_forget_time)) begin
         a_valid = 1'b0; a_lck = 1'b0; a_fcnt = 8'd0; a_lvl = 8'd0;
      end else if (a_lck &&
                   (req_ff.now_ms - lstart_ff[sel]) >= 32'(llen_ff[sel])) begin
         a_lck = 1'b0; a_fcnt = 8'd0;
      end
   end

   // aged view of the global record
   logic        ag_lck;
   logic [7:0]  ag_cnt, ag_lvl;
   logic [31:0] gquiet;
   always_comb begin
      ag_lck = glck_ff;
      ag_cnt = gcnt_ff;
      ag_lvl = glvl_ff;
      gquiet = req_ff.now_ms - glast_ff;
      if (gever_ff) begin
         if (ag_lck && (req_ff.now_ms - gstart_ff) >= 32'(glen_ff)) begin
            ag_lck = 1'b0; ag_cnt = 8'd0;
         end
         if (!ag_lck && gquiet >= 32'(cfg.idle_forget_time))       ag_cnt = 8'd0;
         if (!ag_lck && gquiet >= 32'(cfg.escalation_forget_time)) ag_lvl = 8'd0;
      end
   end

   // failure decisions
   logic [7:0] s_inc, g_inc;
   logic       s_start, g_start;
   assign s_inc   = a_fcnt + 8'd1;
   assign g_inc   = ag_cnt + 8'd1;
   assign s_start = !a_lck && ((a_lvl != 8'd0) || (s_inc >= cfg.ip_fail_limit));
   assign g_start = !ag_lck && (g_inc >= cfg.global_fail_limit);

   // a zero base stays zero, so stepping stops there
   logic s_go, g_go;
   assign s_go = (sk_ff != 8'd0) && (sbo_ff != 28'd0) && (sbo_ff < {1'b0, cfg.ip_lock_cap});
   assign g_go = (gk_ff != 8'd0) && (gbo_ff != 28'd0) &&
                 (gbo_ff < {1'b0, cfg.global_lock_cap});
   assign sts.bo_done = !s_go && !g_go;

   // query remaining times
   logic [26:0] q_g, q_s, q_rem;
   logic        q_s_lck;
   assign q_g     = glen_ff - 27'(req_ff.now_ms - gstart_ff);
   assign q_s_lck = hit_ff && a_lck;
   assign q_s     = llen_ff[sel] - 27'(req_ff.now_ms - lstart_ff[sel]);
   always_comb begin
      q_rem = ag_lck ? q_g : 27'd0;
      if (q_s_lck && q_s > q_rem) q_rem = q_s;
   end

   logic [26:0] s_len, g_len;
   assign s_len = (sbo_ff < {1'b0, cfg.ip_lock_cap}) ? sbo_ff[26:0] : cfg.ip_lock_cap;
   assign g_len = (gbo_ff < {1'b0, cfg.global_lock_cap}) ? gbo_ff[26:0] : cfg.global_lock_cap;

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            valid_ff[i] <= 1'b0; fcnt_ff[i] <= '0; lvl_ff[i] <= '0;
            lck_ff[i] <= 1'b0; lstart_ff[i] <= '0; llen_ff[i] <= '0;
            lfail_ff[i] <= '0; addr_ff[i] <= '0;
         end
         gcnt_ff <= '0; glvl_ff <= '0; glck_ff <= 1'b0; gever_ff <= 1'b0;
         gstart_ff <= '0; glen_ff <= '0; glast_ff <= '0;
         ptr_ff <= '0; hit_ff <= 1'b0; free_ff <= 1'b0;
         sk_ff <= '0; gk_ff <= '0;
      end else begin
         if (cmd.load) begin
            req_ff <= req_data;
         end
         if (cmd.scan_start) begin
            ptr_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            old_idx_ff <= '0;
            old_age_ff <= '0;
         end else if (cmd.scan_step) begin
            if (!sts.scan_done) ptr_ff <= ptr_ff + CW'(1);
            if (valid_ff[pidx] && addr_ff[pidx] == req_ff.source_addr && !hit_ff) begin
               hit_ff <= 1'b1; hit_idx_ff <= pidx;
            end
            if (!valid_ff[pidx] && !free_ff) begin
               free_ff <= 1'b1; free_idx_ff <= pidx;
            end
            if (ptr_ff == '0 || page > old_age_ff) begin
               old_idx_ff <= pidx; old_age_ff <= page;
            end
         end
         if (cmd.bo_start) begin
            sbo_ff <= {1'b0, cfg.ip_lock_base};     sk_ff <= a_lvl;
            gbo_ff <= {1'b0, cfg.global_lock_base}; gk_ff <= ag_lvl;
         end else if (cmd.bo_step) begin
            if (s_go) begin
               sbo_ff <= {sbo_ff[26:0], 1'b0}; sk_ff <= sk_ff - 8'd1;
            end
            if (g_go) begin
               gbo_ff <= {gbo_ff[26:0], 1'b0}; gk_ff <= gk_ff - 8'd1;
            end
         end
         if (cmd.commit) begin
            rsp_ff <= '0;
            unique case (op_type'(req_ff.op))
               OP_QUERY: begin
                  gcnt_ff <= ag_cnt; glvl_ff <= ag_lvl; glck_ff <= ag_lck;
                  if (hit_ff) begin
                     valid_ff[sel] <= a_valid; lck_ff[sel] <= a_lck;
                     fcnt_ff[sel]  <= a_fcnt;  lvl_ff[sel] <= a_lvl;
                  end
                  rsp_ff.is_locked <= ag_lck || q_s_lck;
                  rsp_ff.remain_ms <= q_rem;
               end
               OP_FAILURE: begin
                  valid_ff[sel] <= 1'b1;
                  addr_ff[sel]  <= req_ff.source_addr;
                  lfail_ff[sel] <= req_ff.now_ms;
                  if (s_start) begin
                     lck_ff[sel]    <= 1'b1;
                     lstart_ff[sel] <= req_ff.now_ms;
                     llen_ff[sel]   <= s_len;
                     lvl_ff[sel]    <= (a_lvl == LEVEL_MAX) ? a_lvl : a_lvl + 8'd1;
                     fcnt_ff[sel]   <= 8'd0;
                  end else begin
                     lck_ff[sel]  <= a_lck;
                     lvl_ff[sel]  <= a_lvl;
                     fcnt_ff[sel] <= a_lck ? a_fcnt : s_inc;
                     if (!a_valid) begin
                        lstart_ff[sel] <= '0; llen_ff[sel] <= '0;
                     end
                  end
                  glast_ff <= req_ff.now_ms;
                  gever_ff <= 1'b1;
                  if (g_start) begin
                     glck_ff   <= 1'b1;
                     gstart_ff <= req_ff.now_ms;
                     glen_ff   <= g_len;
                     glvl_ff   <= (ag_lvl == LEVEL_MAX) ? ag_lvl : ag_lvl + 8'd1;
                     gcnt_ff   <= 8'd0;
                  end else begin
                     glck_ff <= ag_lck;
                     glvl_ff <= ag_lvl;
                     gcnt_ff <= ag_lck ? ag_cnt : g_inc;
                  end
                  rsp_ff.lock_started <= s_start || g_start;
               end
               OP_SUCCESS: begin
                  if (hit_ff) begin
                     valid_ff[sel] <= 1'b0; fcnt_ff[sel] <= '0; lvl_ff[sel] <= '0;
                     lck_ff[sel] <= 1'b0; lstart_ff[sel] <= '0; llen_ff[sel] <= '0;
                     lfail_ff[sel] <= '0; addr_ff[sel] <= '0;
                  end
                  gcnt_ff <= 8'd0;
               end
               OP_CLEAR: begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     valid_ff[i] <= 1'b0; fcnt_ff[i] <= '0; lvl_ff[i] <= '0;
                     lck_ff[i] <= 1'b0; lstart_ff[i] <= '0; llen_ff[i] <= '0;
                     lfail_ff[i] <= '0; addr_ff[i] <= '0;
                  end
                  gcnt_ff <= '0; glvl_ff <= '0; glck_ff <= 1'b0; gever_ff <= 1'b0;
                  gstart_ff <= '0; glen_ff <= '0; glast_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && req_ff.op != OP_FAILURE |=> !rsp_ff.lock_started)
      else $error("lock_started on non-failure beat");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && req_ff.op != OP_QUERY |=> rsp_ff.remain_ms == 27'd0)
      else $error("remain on non-query beat");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && req_ff.op == OP_FAILURE |=> valid_ff[$past(sel)])
      else $error("failure did not leave a valid slot");

endmodule
`default_nettype wire

/* rtl/lfle_regs.sv */
// Configuration register file for the lockout engine.
`default_nettype none
module lfle_regs
   import lfle_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [26:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ip_fail_limit          <= IP_FAIL_LIMIT_RST;
         cfg_ff.ip_lock_base           <= IP_LOCK_BASE_RST;
         cfg_ff.ip_lock_cap            <= IP_LOCK_CAP_RST;
         cfg_ff.global_fail_limit      <= GLB_FAIL_LIMIT_RST;
         cfg_ff.global_lock_base       <= GLB_LOCK_BASE_RST;
         cfg_ff.global_lock_cap        <= GLB_LOCK_CAP_RST;
         cfg_ff.idle_forget_time       <= IDLE_FORGET_RST;
         cfg_ff.escalation_forget_time <= ESC_FORGET_RST;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_IP_FAIL_LIMIT:  cfg_ff.ip_fail_limit          <= csr_data[7:0];
            REG_IP_LOCK_BASE:   cfg_ff.ip_lock_base           <= csr_data;
            REG_IP_LOCK_CAP:    cfg_ff.ip_lock_cap            <= csr_data;
            REG_GLB_FAIL_LIMIT: cfg_ff.global_fail_limit      <= csr_data[7:0];
            REG_GLB_LOCK_BASE:  cfg_ff.global_lock_base       <= csr_data;
            REG_GLB_LOCK_CAP:   cfg_ff.global_lock_cap        <= csr_data;
            REG_IDLE_FORGET:    cfg_ff.idle_forget_time       <= csr_data;
            REG_ESC_FORGET:     cfg_ff.escalation_forget_time <= csr_data;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire
